// File: hw/rtl/tlsc_pkg.sv
package tlsc_pkg;

  localparam int ENTRIES = 255;
  localparam int MODELS  = 1024;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);

  localparam logic [16:0] MODEL_LIM = 17'(MODELS);
  localparam logic [7:0]  TEX_MASK  = 8'hff;

  localparam logic [1:0] ST_HIT     = 2'd0;
  localparam logic [1:0] ST_FILL    = 2'd1;
  localparam logic [1:0] ST_REPLACE = 2'd2;
  localparam logic [1:0] ST_INVALID = 2'd3;

  typedef struct packed {
    logic [15:0] model_num;
    logic [3:0]  part_code;
    logic [31:0] texture_raw;
    logic [31:0] tint_value;
    logic [8:0]  skin_count;
    logic [31:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic [7:0] slot;
    logic [1:0] status;
    logic [7:0] texture_used;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  part;
    logic [15:0] model;
    logic [7:0]  texture;
    logic [31:0] tint;
    logic [31:0] stamp;
  } entry_t;

endpackage

// File: hw/rtl/tlsc_store.sv
module tlsc_store (
  input  logic                      clk,
  input  logic                      rd_en,
  input  logic [tlsc_pkg::IDX_W-1:0] rd_addr,
  output tlsc_pkg::entry_t          rd_data,
  input  logic                      wr_en,
  input  logic [tlsc_pkg::IDX_W-1:0] wr_addr,
  input  tlsc_pkg::entry_t          wr_data
);

  tlsc_pkg::entry_t mem [tlsc_pkg::ENTRIES];
  tlsc_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: hw/rtl/tagged_lru_slot_cache_top.sv
// Channel   Ports                  Handshake
// input     start, busy, in_item   taken when start is high and busy is low
// result    out_valid, out_item    one-cycle strobe, one result per item
//
// An invalid request is answered in the cycle after it is taken and leaves busy low.
// A valid request scans the N occupied entries at one per cycle through the
// store's registered read port and stops at the first hit.
// With all ENTRIES entries occupied and no hit, a second pass over the stamps
// follows to pick the entry with the lowest stamp for replacement.
// Reset is synchronous and empties the cache at once through a fill count.
// The receiver cannot stall; busy stays high while an item is in work.
module tagged_lru_slot_cache_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  tlsc_pkg::in_item_t  in_item,
  output logic                out_valid,
  output tlsc_pkg::out_item_t out_item
);

  localparam int IDX_W = tlsc_pkg::IDX_W;
  localparam int CNT_W = tlsc_pkg::CNT_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_LRU   = 2'd2;
  localparam logic [1:0] S_WRITE = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] iss_r, iss_nxt;
  logic             pv_r, pv_nxt;
  logic [IDX_W-1:0] pidx_r, pidx_nxt;
  logic [CNT_W-1:0] fill_cnt_r, fill_cnt_nxt;
  logic [31:0]      min_stamp_r, min_stamp_nxt;
  logic [IDX_W-1:0] victim_r, victim_nxt;
  logic [1:0]       status_r, status_nxt;
  logic             out_valid_r, out_valid_nxt;
  tlsc_pkg::out_item_t out_item_r, out_item_nxt;

  logic [15:0] key_model_r;
  logic [3:0]  key_part_r;
  logic [7:0]  key_tex_r;
  logic [31:0] key_tint_r;
  logic [31:0] key_now_r;

  logic             accept;
  logic [7:0]       tex_used;
  logic             req_bad;
  logic             issue;
  logic             rd_en;
  logic             wr_en;
  logic             key_match;
  logic             last_used;
  logic             take_min;
  tlsc_pkg::entry_t rd_data;
  tlsc_pkg::entry_t wr_data;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    tex_used = in_item.texture_raw[7:0] & tlsc_pkg::TEX_MASK;
    if (in_item.skin_count <= {1'b0, tex_used}) begin
      tex_used = 8'd0;
    end
    req_bad = (in_item.model_num == 16'd0) ||
              ({1'b0, in_item.model_num} >= tlsc_pkg::MODEL_LIM) ||
              (in_item.part_code == 4'd0);
  end

  tlsc_store u_store (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (iss_r[IDX_W-1:0]),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (victim_r),
    .wr_data (wr_data)
  );

  assign key_match = (rd_data.model == key_model_r) && (rd_data.part == key_part_r) &&
                     (rd_data.texture == key_tex_r) && (rd_data.tint == key_tint_r);
  assign last_used = ((CNT_W'(pidx_r) + CNT_W'(1)) == fill_cnt_r);
  assign take_min  = (pidx_r == IDX_W'(0)) || (rd_data.stamp < min_stamp_r);

  assign wr_en = (state_r == S_WRITE);
  assign wr_data = '{part: key_part_r, model: key_model_r, texture: key_tex_r,
                     tint: key_tint_r, stamp: key_now_r};

  always_comb begin
    issue = 1'b0;
    case (state_r)
      S_SCAN:  issue = (iss_r < fill_cnt_r);
      S_LRU:   issue = (iss_r < CNT_W'(tlsc_pkg::ENTRIES));
      default: issue = 1'b0;
    endcase
    rd_en = issue;
  end

  always_comb begin
    state_nxt     = state_r;
    iss_nxt       = issue ? iss_r + CNT_W'(1) : iss_r;
    pv_nxt        = issue;
    pidx_nxt      = iss_r[IDX_W-1:0];
    fill_cnt_nxt  = fill_cnt_r;
    min_stamp_nxt = min_stamp_r;
    victim_nxt    = victim_r;
    status_nxt    = status_r;
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          iss_nxt = '0;
          pv_nxt  = 1'b0;
          out_item_nxt.texture_used = tex_used;
          if (req_bad) begin
            out_valid_nxt       = 1'b1;
            out_item_nxt.slot   = 8'd0;
            out_item_nxt.status = tlsc_pkg::ST_INVALID;
          end else if (fill_cnt_r == '0) begin
            victim_nxt = '0;
            status_nxt = tlsc_pkg::ST_FILL;
            state_nxt  = S_WRITE;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (pv_r) begin
          if (key_match) begin
            victim_nxt = pidx_r;
            status_nxt = tlsc_pkg::ST_HIT;
            state_nxt  = S_WRITE;
            pv_nxt     = 1'b0;
          end else if (last_used) begin
            pv_nxt  = 1'b0;
            iss_nxt = '0;
            if (fill_cnt_r < CNT_W'(tlsc_pkg::ENTRIES)) begin
              victim_nxt = fill_cnt_r[IDX_W-1:0];
              status_nxt = tlsc_pkg::ST_FILL;
              state_nxt  = S_WRITE;
            end else begin
              state_nxt = S_LRU;
            end
          end
        end
      end
      S_LRU: begin
        if (pv_r) begin
          // The strict compare keeps the first entry among equal stamps.
          if (take_min) begin
            min_stamp_nxt = rd_data.stamp;
            victim_nxt    = pidx_r;
          end
          if (pidx_r == IDX_W'(tlsc_pkg::ENTRIES - 1)) begin
            status_nxt = tlsc_pkg::ST_REPLACE;
            state_nxt  = S_WRITE;
            pv_nxt     = 1'b0;
          end
        end
      end
      S_WRITE: begin
        pv_nxt              = 1'b0;
        out_valid_nxt       = 1'b1;
        out_item_nxt.slot   = 8'(victim_r);
        out_item_nxt.status = status_r;
        if (status_r == tlsc_pkg::ST_FILL) begin
          fill_cnt_nxt = fill_cnt_r + CNT_W'(1);
        end
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      iss_r       <= '0;
      pv_r        <= 1'b0;
      fill_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      iss_r       <= iss_nxt;
      pv_r        <= pv_nxt;
      fill_cnt_r  <= fill_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pidx_r      <= pidx_nxt;
    min_stamp_r <= min_stamp_nxt;
    victim_r    <= victim_nxt;
    status_r    <= status_nxt;
    out_item_r  <= out_item_nxt;
    if (accept) begin
      key_model_r <= in_item.model_num;
      key_part_r  <= in_item.part_code;
      key_tex_r   <= tex_used;
      key_tint_r  <= in_item.tint_value;
      key_now_r   <= in_item.now_time;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

`ifndef SYNTH
  a_out_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while an item is still in work");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_cnt_r <= CNT_W'(tlsc_pkg::ENTRIES))
    else $error("fill count beyond the number of entries");

  a_valid_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && !req_bad |=> busy)
    else $error("valid request did not start a lookup");

  a_replace_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item.status == tlsc_pkg::ST_REPLACE) |->
      fill_cnt_r == CNT_W'(tlsc_pkg::ENTRIES))
    else $error("replacement while empty entries remain");
`endif

endmodule

// File: bench/tagged_lru_slot_cache_top_tb.sv
`timescale 1ns / 1ps

module tagged_lru_slot_cache_top_tb;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 520;

  typedef struct {
    logic [15:0] model;
    logic [3:0]  part;
    logic [7:0]  tex;
    logic [31:0] tint;
  } cache_key_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                start;
  logic                busy;
  tlsc_pkg::in_item_t  in_item;
  logic                out_valid;
  tlsc_pkg::out_item_t out_item;

  tlsc_pkg::entry_t    cache_entries [tlsc_pkg::ENTRIES];
  tlsc_pkg::out_item_t expected_results [$];
  cache_key_t          key_pool [$];
  int                  error_count;
  int                  quiet_cycles;
  int                  idle_pct;
  int                  wild_stamp_pct;
  int unsigned         stamp_clock;

  tagged_lru_slot_cache_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t mismatch on %s: got %0d, expected %0d", $time, field, got, want);
    error_count++;
  endtask

  // Computes the result of one lookup and updates the local copy of the store.
  function automatic tlsc_pkg::out_item_t predict_lookup(tlsc_pkg::in_item_t req);
    tlsc_pkg::out_item_t res;
    logic [7:0] tex;
    int victim;
    int i;
    tex = req.texture_raw[7:0] & tlsc_pkg::TEX_MASK;
    if (req.skin_count <= {1'b0, tex}) tex = '0;
    res.texture_used = tex;
    res.slot = '0;
    res.status = tlsc_pkg::ST_INVALID;
    if (req.model_num == 16'd0 || {1'b0, req.model_num} >= tlsc_pkg::MODEL_LIM ||
        req.part_code == 4'd0)
      return res;
    victim = tlsc_pkg::ENTRIES;
    for (i = 0; i < tlsc_pkg::ENTRIES; i++) begin
      if (cache_entries[i].part == 4'd0) begin
        victim = i;
        break;
      end
      if (cache_entries[i].model == req.model_num && cache_entries[i].part == req.part_code &&
          cache_entries[i].texture == tex && cache_entries[i].tint == req.tint_value) begin
        cache_entries[i].stamp = req.now_time;
        res.slot = 8'(i);
        res.status = tlsc_pkg::ST_HIT;
        return res;
      end
    end
    if (victim < tlsc_pkg::ENTRIES) begin
      res.status = tlsc_pkg::ST_FILL;
    end else begin
      victim = 0;
      for (i = 1; i < tlsc_pkg::ENTRIES; i++) begin
        if (cache_entries[i].stamp < cache_entries[victim].stamp) victim = i;
      end
      res.status = tlsc_pkg::ST_REPLACE;
    end
    cache_entries[victim].part    = req.part_code;
    cache_entries[victim].model   = req.model_num;
    cache_entries[victim].texture = tex;
    cache_entries[victim].tint    = req.tint_value;
    cache_entries[victim].stamp   = req.now_time;
    res.slot = 8'(victim);
    return res;
  endfunction

  // Drives one item, waits until the block takes it, then maybe idles a while.
  task automatic send_request(input tlsc_pkg::in_item_t req);
    int gap;
    @(negedge clk);
    start <= 1'b1;
    in_item <= req;
    do @(posedge clk); while (busy);
    expected_results.push_back(predict_lookup(req));
    if ($urandom_range(99) < idle_pct) begin
      // Mostly short gaps; now and then one long enough to cover a full scan.
      gap = ($urandom_range(15) == 0) ? $urandom_range(10, 520) : $urandom_range(1, 6);
      repeat (gap) begin
        @(negedge clk);
        start <= 1'b0;
        in_item <= tlsc_pkg::in_item_t'({$urandom, $urandom, $urandom, $urandom});
      end
    end
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic tlsc_pkg::in_item_t make_request(logic [15:0] model, logic [3:0] part,
                                                      logic [31:0] tex, logic [31:0] tint,
                                                      logic [8:0] skins, logic [31:0] now);
    tlsc_pkg::in_item_t r;
    r.model_num   = model;
    r.part_code   = part;
    r.texture_raw = tex;
    r.tint_value  = tint;
    r.skin_count  = skins;
    r.now_time    = now;
    return r;
  endfunction

  function automatic logic [31:0] next_now();
    if ($urandom_range(99) < wild_stamp_pct) return $urandom;
    stamp_clock += $urandom_range(1, 16);
    return stamp_clock;
  endfunction

  // New keys are either fresh or a copy of an existing key with one field changed,
  // so that near misses on every key field occur.
  task automatic grow_key_pool(input int count);
    cache_key_t k;
    repeat (count) begin
      if (key_pool.size() != 0 && $urandom_range(9) < 3) begin
        k = key_pool[$urandom_range(key_pool.size() - 1)];
        case ($urandom_range(3))
          0: k.model = 16'($urandom_range(1, tlsc_pkg::MODELS - 1));
          1: k.part  = 4'($urandom_range(1, 15));
          2: k.tex   = 8'($urandom_range(0, 255));
          default: k.tint = k.tint ^ (32'd1 << $urandom_range(31));
        endcase
      end else begin
        k.model = 16'($urandom_range(1, tlsc_pkg::MODELS - 1));
        k.part  = 4'($urandom_range(1, 15));
        k.tex   = 8'($urandom_range(0, 255));
        k.tint  = ($urandom_range(1) == 0) ? $urandom : 32'($urandom_range(0, 3));
      end
      key_pool.push_back(k);
    end
  endtask

  function automatic tlsc_pkg::in_item_t keyed_request(int hot_size);
    cache_key_t k;
    tlsc_pkg::in_item_t r;
    int limit;
    limit = (hot_size > 0 && hot_size < key_pool.size()) ? hot_size : key_pool.size();
    k = key_pool[$urandom_range(limit - 1)];
    r.model_num   = k.model;
    r.part_code   = k.part;
    r.texture_raw = $urandom;
    r.texture_raw[7:0] = k.tex;
    r.tint_value  = k.tint;
    // Usually the skin count keeps the texture as is; sometimes it may clamp it.
    if ($urandom_range(9) == 0) r.skin_count = 9'($urandom_range(0, 256));
    else r.skin_count = 9'($urandom_range(256, k.tex + 1));
    r.now_time    = next_now();
    return r;
  endfunction

  function automatic tlsc_pkg::in_item_t noise_request();
    tlsc_pkg::in_item_t r;
    r.model_num   = 16'($urandom);
    r.part_code   = 4'($urandom_range(0, 15));
    r.texture_raw = $urandom;
    r.tint_value  = $urandom;
    r.skin_count  = 9'($urandom_range(0, 256));
    r.now_time    = next_now();
    case ($urandom_range(3))
      0: r.model_num = '0;
      1: r.part_code = '0;
      2: r.model_num = 16'($urandom_range(tlsc_pkg::MODELS, 16'hffff));
      default: ;
    endcase
    return r;
  endfunction

  task automatic test_invalid_requests();
    idle_pct = 0;
    send_request(make_request(16'd0, 4'd1, 32'd5, 32'd0, 9'd10, 32'd0));
    send_request(make_request(16'(tlsc_pkg::MODELS), 4'd3, 32'd2, 32'd7, 9'd3, 32'd1));
    send_request(make_request(16'hffff, 4'hf, 32'hffff_ffff, 32'hffff_ffff, 9'd256,
                              32'hffff_ffff));
    send_request(make_request(16'd1, 4'd0, 32'h1234_56ff, 32'h5a5a_5a5a, 9'd0, 32'd2));
    send_request(make_request(16'(tlsc_pkg::MODELS - 1), 4'd0, 32'h0000_0080, 32'd0, 9'd128,
                              32'd3));
    send_request(make_request(16'd0, 4'd0, 32'hffff_ff00, 32'd1, 9'd256, 32'd4));
  endtask

  task automatic test_fill_and_hit();
    idle_pct = 0;
    send_request(make_request(16'd1, 4'd1, 32'd0, 32'd0, 9'd1, 32'd0));
    send_request(make_request(16'd1, 4'd1, 32'hffff_ff00, 32'd0, 9'd256, 32'd10));
    // A texture at or above the skin count collapses to texture zero.
    send_request(make_request(16'(tlsc_pkg::MODELS - 1), 4'd8, 32'hffff_ff07, 32'd9, 9'd7,
                              32'd11));
    send_request(make_request(16'(tlsc_pkg::MODELS - 1), 4'd8, 32'd0, 32'd9, 9'd7, 32'd12));
    send_request(make_request(16'd77, 4'd9, 32'd3, 32'd1, 9'd4, 32'd13));
    send_request(make_request(16'd77, 4'd15, 32'd3, 32'd1, 9'd4, 32'd14));
    send_request(make_request(16'd77, 4'd9, 32'd3, 32'hffff_ffff, 9'd4, 32'hffff_ffff));
    send_request(make_request(16'd200, 4'd4, 32'h0000_00ff, 32'd2, 9'd256, 32'd15));
    send_request(make_request(16'd200, 4'd4, 32'h0000_00ff, 32'd2, 9'd255, 32'd16));
    send_request(make_request(16'd0, 4'd4, 32'h0000_00ff, 32'd2, 9'd256, 32'd17));
    send_request(make_request(16'd200, 4'd4, 32'hab00_00ff, 32'd2, 9'd256, 32'd18));
    send_request(make_request(16'd1, 4'd1, 32'd0, 32'd0, 9'd1, 32'd5));
    send_request(make_request(16'd77, 4'd15, 32'd3, 32'd1, 9'd4, 32'd0));
    send_request(make_request(16'd78, 4'd9, 32'd3, 32'd1, 9'd4, 32'd19));
    send_request(make_request(16'd77, 4'd9, 32'd2, 32'd1, 9'd4, 32'd20));
  endtask

  task automatic test_random_fill();
    idle_pct = 0;
    wild_stamp_pct = 5;
    grow_key_pool(200);
    repeat (320) send_request(keyed_request(0));
  endtask

  // The store fills up early in this test, after which every miss evicts the oldest stamp.
  task automatic test_lru_replace();
    idle_pct = 55;
    wild_stamp_pct = 20;
    grow_key_pool(200);
    repeat (420) begin
      if ($urandom_range(9) < 6) send_request(keyed_request(120));
      else send_request(keyed_request(0));
    end
  endtask

  task automatic test_mixed_noise();
    idle_pct = 32;
    wild_stamp_pct = 10;
    repeat (420) begin
      if ($urandom_range(99) < 70) send_request(keyed_request(150));
      else send_request(noise_request());
    end
  endtask

  always @(posedge clk) begin
    tlsc_pkg::out_item_t want;
    if (rst_n) begin
      if ((start && !busy) || out_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tagged_lru_slot_cache_top verification failed");
        $finish;
      end
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result slot", 32'(out_item.slot), 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_item.slot !== want.slot)
            report_mismatch("slot", 32'(out_item.slot), 32'(want.slot));
          if (out_item.status !== want.status)
            report_mismatch("status", 32'(out_item.status), 32'(want.status));
          if (out_item.texture_used !== want.texture_used)
            report_mismatch("texture_used", 32'(out_item.texture_used),
                            32'(want.texture_used));
        end
      end
    end
  end

  initial begin
    error_count = 0;
    quiet_cycles = 0;
    idle_pct = 0;
    wild_stamp_pct = 0;
    stamp_clock = 32'd100;
    foreach (cache_entries[i]) cache_entries[i] = '0;
    rst_n = 1'b0;
    start = 1'b0;
    in_item = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_invalid_requests();
    test_fill_and_hit();
    test_random_fill();
    // Hold the sender off until every outstanding result has come back.
    wait_for_drain();
    test_lru_replace();
    test_mixed_noise();

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results still outstanding", 32'd0, 32'(expected_results.size()));
    if (error_count == 0) begin
      $display("tagged_lru_slot_cache_top verification clean");
    end else begin
      $display("tagged_lru_slot_cache_top verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/tlsc_pkg.sv
hw/rtl/tlsc_store.sv
hw/rtl/tagged_lru_slot_cache_top.sv
bench/tagged_lru_slot_cache_top_tb.sv
